// ----- src/lgg_pkg.sv -----
package lgg_pkg;

    // Default grid size.
    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;

    // Field widths of an input word.
    localparam int OP_W  = 2;
    localparam int ROW_W = 6;
    localparam int COL_W = 6;

    // Port widths.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 64;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SET  = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Control handed to the row update unit for the row at the head of the chain.
    typedef struct packed {
        logic             step;
        logic             set_hit;
        logic             value;
        logic [COL_W-1:0] col;
    } upd_ctrl_t;

endpackage

// ----- src/life_grid_generation.sv -----
// Channel  | Ports                     | Word
// ---------+---------------------------+---------------------------------------
// input    | s_tvalid s_tready s_tdata | operation, row, col, value
// result   | m_tvalid m_tready m_tdata | row_bits, one per input word
//
// Every operation walks the chain of row cells once: the word is taken, and then one row
// word is updated per cycle, all columns in parallel.
// A result is handed to the output register at the end of the walk; a new
// input word is taken as soon as the walk is over, while the result waits.
// A stalled result holds the block at the end of the walk until it is taken.
// Synchronous reset clears the whole grid at once; no clearing pass is needed.
module life_grid_generation
    import lgg_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // operation[1:0] row[7:2] col[13:8] value[14]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // row_bits[63:0]
);

    localparam int CNT_W = $clog2(GRID_ROWS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_HOLD
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [OP_W-1:0]      op_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic                 value_reg;
    logic [GRID_COLS-1:0] prior_reg;
    logic [GRID_COLS-1:0] result_reg;
    logic                 m_tvalid_reg;
    logic [GRID_COLS-1:0] m_data_reg;

    logic [GRID_COLS-1:0] chain [GRID_ROWS];
    logic [GRID_COLS-1:0] row_new;
    logic [GRID_COLS-1:0] below;
    logic                 sweeping;
    logic                 last_row;
    logic                 row_hit;
    logic                 out_free;
    logic                 m_load;
    logic                 s_accept;
    upd_ctrl_t            ctrl;

    assign sweeping = (state_reg == ST_SWEEP);
    assign last_row = (cnt_reg == CNT_W'(GRID_ROWS - 1));
    assign row_hit  = (ROW_W'(cnt_reg) == row_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_load   = out_free && ((sweeping && last_row) || (state_reg == ST_HOLD));
    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // The row below the head; past the last row it is dead.
    assign below = last_row ? '0 : chain[1];

    assign ctrl.step    = (op_reg == OP_STEP);
    assign ctrl.set_hit = (op_reg == OP_SET) && row_hit && (int'(col_reg) < GRID_COLS);
    assign ctrl.value   = value_reg;
    assign ctrl.col     = col_reg;

    // Chain of row cells: cell 0 is the head, the tail takes the updated row.
    for (genvar i = 0; i < GRID_ROWS; i++) begin : g_cell
        logic [GRID_COLS-1:0] feed;
        if (i == GRID_ROWS - 1) begin : g_tail
            assign feed = row_new;
        end else begin : g_body
            assign feed = chain[i+1];
        end
        lgg_row_cell #(
            .WIDTH (GRID_COLS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (sweeping),
            .row_in  (feed),
            .row_out (chain[i])
        );
    end

    lgg_row_update #(
        .WIDTH (GRID_COLS)
    ) u_update (
        .ctrl    (ctrl),
        .above   (prior_reg),
        .cur     (chain[0]),
        .below   (below),
        .row_new (row_new)
    );

    // Sequencer, input capture and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            prior_reg    <= '0;
        end else begin
            // The output word is loaded at the end of a walk and dropped once taken.
            if (m_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        op_reg     <= s_tdata[1:0];
                        row_reg    <= s_tdata[7:2];
                        col_reg    <= s_tdata[13:8];
                        value_reg  <= s_tdata[14];
                        prior_reg  <= '0;
                        result_reg <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (ctrl.step) begin
                        prior_reg <= chain[0];
                    end
                    if (last_row) begin
                        cnt_reg <= '0;
                        if (out_free) begin
                            m_data_reg <= row_hit ? row_new : result_reg;
                            state_reg  <= ST_IDLE;
                        end else begin
                            state_reg <= ST_HOLD;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (row_hit) begin
                        result_reg <= row_new;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        m_data_reg <= result_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

    // An accepted word always starts a walk from the head row.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_SWEEP) && (cnt_reg == '0))
        else $error("accepted word did not start a walk at row zero");

    // A walk ends after exactly the last row.
    a_walk_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        sweeping && last_row |=> (state_reg != ST_SWEEP))
        else $error("walk did not end after the last row");

    // The block only waits at the end of a walk while a result is pending.
    a_hold_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> m_tvalid_reg)
        else $error("holding a result without a pending output word");

    // A walk ending with a free output register yields a result next cycle.
    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        sweeping && last_row && out_free |=> m_tvalid_reg && (state_reg == ST_IDLE))
        else $error("finished walk did not present its result");

endmodule

// ----- src/lgg_row_cell.sv -----
module lgg_row_cell
    import lgg_pkg::*;
#(
    parameter int WIDTH = GRID_COLS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift,
    input  logic [WIDTH-1:0] row_in,
    output logic [WIDTH-1:0] row_out
);

    logic [WIDTH-1:0] row_reg;

    // One row of the grid; takes its neighbour's row on every shift.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else if (shift) begin
            row_reg <= row_in;
        end
    end

    assign row_out = row_reg;

endmodule

// ----- src/lgg_row_update.sv -----
module lgg_row_update
    import lgg_pkg::*;
#(
    parameter int WIDTH = GRID_COLS_DEF
) (
    input  upd_ctrl_t        ctrl,
    input  logic [WIDTH-1:0] above,
    input  logic [WIDTH-1:0] cur,
    input  logic [WIDTH-1:0] below,
    output logic [WIDTH-1:0] row_new
);

    logic [WIDTH+1:0] a_ext;
    logic [WIDTH+1:0] c_ext;
    logic [WIDTH+1:0] b_ext;
    logic [WIDTH-1:0] life_row;
    logic [WIDTH-1:0] set_mask;

    // Dead cells pad both edges, so there is no wrap-around.
    assign a_ext = {1'b0, above, 1'b0};
    assign c_ext = {1'b0, cur, 1'b0};
    assign b_ext = {1'b0, below, 1'b0};

    // B3/S23 rule, all columns in parallel.
    always_comb begin
        logic [3:0] n;
        n        = '0;
        life_row = '0;
        for (int x = 0; x < WIDTH; x++) begin
            n = 4'(a_ext[x]) + 4'(a_ext[x+1]) + 4'(a_ext[x+2])
              + 4'(c_ext[x]) + 4'(c_ext[x+2])
              + 4'(b_ext[x]) + 4'(b_ext[x+1]) + 4'(b_ext[x+2]);
            life_row[x] = (n == 4'd3) || ((n == 4'd2) && cur[x]);
        end
    end

    assign set_mask = {{(WIDTH-1){1'b0}}, 1'b1} << ctrl.col;

    // Choose the word that goes back into the tail of the chain.
    always_comb begin
        if (ctrl.step) begin
            row_new = life_row;
        end else if (ctrl.set_hit) begin
            row_new = ctrl.value ? (cur | set_mask) : (cur & ~set_mask);
        end else begin
            row_new = cur;
        end
    end

endmodule
